// ----- design/relocation_field_patcher_top_assert.svh -----
// ---------------------------------------------------------------------------
// relocation field patcher assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef RELOCATION_FIELD_PATCHER_TOP_ASSERT_SVH
`define RELOCATION_FIELD_PATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define RFP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("relocation field patcher: property failed");

// next-cycle implication
`define RFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("relocation field patcher: property failed");

`endif

// ----- design/rfp_pkg.sv -----
// ---------------------------------------------------------------------------
// rfp_pkg
// kinds, status codes, beat and stage types for the relocation field patcher
// ---------------------------------------------------------------------------
package rfp_pkg;

   // relocation kinds
   localparam logic [4:0] KIND_RV_B    = 5'd0;
   localparam logic [4:0] KIND_RV_J    = 5'd1;
   localparam logic [4:0] KIND_HI20    = 5'd2;
   localparam logic [4:0] KIND_LO12    = 5'd3;
   localparam logic [4:0] KIND_ADR     = 5'd4;
   localparam logic [4:0] KIND_TBZ14   = 5'd5;
   localparam logic [4:0] KIND_CB19    = 5'd6;
   localparam logic [4:0] KIND_J26     = 5'd7;
   localparam logic [4:0] KIND_ABS64   = 5'd8;
   localparam logic [4:0] KIND_REL64   = 5'd9;
   localparam logic [4:0] KIND_ABS32   = 5'd10;
   localparam logic [4:0] KIND_ABS32S  = 5'd11;
   localparam logic [4:0] KIND_REL32   = 5'd12;
   localparam logic [4:0] KIND_ABS16   = 5'd13;
   localparam logic [4:0] KIND_REL16   = 5'd14;
   localparam logic [4:0] KIND_ABS8    = 5'd15;
   localparam logic [4:0] KIND_REL8    = 5'd16;

   // result status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FIT   = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   localparam int BASE_W = 48;
   localparam int DIST_W = 36;
   localparam int ABS_W  = 51;

   // accepted request beat
   typedef struct packed {
      logic [4:0]         req_type;
      logic [31:0]        symbol_offset;
      logic [31:0]        site_offset;
      logic signed [31:0] addend;
      logic [31:0]        site_word;
   } req_item_type;

   // resolved distances
   typedef struct packed {
      logic [4:0]               kind;
      logic [31:0]              word;
      logic signed [DIST_W-1:0] rel_dist;
      logic signed [DIST_W-1:0] adr_dist;
      logic signed [ABS_W-1:0]  abs_val;
   } resolve_type;

   // checked field
   typedef struct packed {
      logic        is_data;
      logic [1:0]  status;
      logic [3:0]  bytes;
      logic [31:0] imm;
      logic [63:0] value;
      logic [31:0] word;
   } check_type;

   // result beat
   typedef struct packed {
      logic [63:0] patched_value;
      logic [3:0]  write_bytes;
      logic [1:0]  status;
   } rsp_item_type;

   // signed fit of a distance in a field of the given width
   function automatic logic fits_signed(input logic signed [DIST_W-1:0] v,
                                        input int unsigned bits);
      logic signed [DIST_W-1:0] lim;
      lim = DIST_W'(1) <<< (bits - 1);
      return (v >= -lim) && (v < lim);
   endfunction

endpackage

// ----- design/relocation_field_patcher_top.sv -----
// ---------------------------------------------------------------------------
// relocation_field_patcher_top
// applies one relocation per request beat and returns the patched bytes
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one relocation per beat: kind in req_tuser, offsets,
//   addend and the existing site word in req_tdata.
//   rsp_* returns one beat per request, in order: the patched value and the
//   byte count in rsp_tdata, the status code in rsp_tuser.
//   csr_wr_en / csr_wr_data set the load base used by absolute kinds; write
//   it only while no beat is in flight.
// A request beat passes the resolve, check and merge stage registers before its
// result beat. Throughput is one beat per cycle while rsp_tready stays high.
// Reset clears all stage valid bits and the load base; no result is shown
// until a new request arrives.
// When rsp_tready is low the result beat holds; earlier stages keep filling
// until every stage is occupied, then req_tready drops.
// ---------------------------------------------------------------------------
module relocation_field_patcher_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // symbol_offset, site_offset, addend, site_word
   input  logic [127:0] req_tdata,
   // req_type
   input  logic [4:0]   req_tuser,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // patched_value, write_bytes, zero pad
   output logic [71:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   // configuration
   input  logic         csr_wr_en,
   input  logic [47:0]  csr_wr_data
);
   import rfp_pkg::*;

   logic [BASE_W-1:0] load_base_ff, load_base_in;
   req_item_type      req_item;
   resolve_type       res_item;
   check_type         chk_item;
   rsp_item_type      rsp_item;
   logic              res_valid, res_ready, chk_valid, chk_ready;

   // load base register
   assign load_base_in = csr_wr_en ? csr_wr_data : load_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_base_ff <= '0;
      end else begin
         load_base_ff <= load_base_in;
      end
   end

   // unpack request beat
   assign req_item.req_type      = req_tuser;
   assign req_item.symbol_offset = req_tdata[31:0];
   assign req_item.site_offset   = req_tdata[63:32];
   assign req_item.addend        = $signed(req_tdata[95:64]);
   assign req_item.site_word     = req_tdata[127:96];

   rfp_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .load_base (load_base_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (res_valid),
      .out_ready (res_ready),
      .out_item  (res_item)
   );

   rfp_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_item   (res_item),
      .out_valid (chk_valid),
      .out_ready (chk_ready),
      .out_item  (chk_item)
   );

   rfp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chk_valid),
      .in_ready  (chk_ready),
      .in_item   (chk_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // pack result beat
   assign rsp_tdata = {4'b0, rsp_item.write_bytes, rsp_item.patched_value};
   assign rsp_tuser = rsp_item.status;

endmodule

// ----- design/rfp_resolve.sv -----
// ---------------------------------------------------------------------------
// rfp_resolve
// first stage: relative distance, adr distance and absolute address
// ---------------------------------------------------------------------------
module rfp_resolve (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rfp_pkg::BASE_W-1:0]   load_base,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rfp_pkg::req_item_type        in_item,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rfp_pkg::resolve_type         out_item
);
   import rfp_pkg::*;

   logic        valid_ff, valid_in;
   resolve_type item_ff, item_in, calc;
   logic signed [DIST_W-1:0] add_ext;

   // distance arithmetic
   always_comb begin
      add_ext       = DIST_W'(in_item.addend);
      calc.kind     = in_item.req_type;
      calc.word     = in_item.site_word;
      calc.adr_dist = $signed({4'b0, in_item.symbol_offset})
                    - $signed({4'b0, in_item.site_offset});
      calc.rel_dist = calc.adr_dist + add_ext;
      calc.abs_val  = $signed({19'b0, in_item.symbol_offset})
                    + $signed({3'b0, load_base})
                    + ABS_W'(in_item.addend);
   end

   // stage handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign item_in   = (in_valid && in_ready) ? calc : item_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- design/rfp_check.sv -----
// ---------------------------------------------------------------------------
// rfp_check
// second stage: alignment and range checks, field extraction per kind
// ---------------------------------------------------------------------------
module rfp_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rfp_pkg::resolve_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfp_pkg::check_type   out_item
);
   import rfp_pkg::*;

   logic      valid_ff, valid_in;
   check_type item_ff, item_in, calc;
   logic signed [DIST_W-1:0] rel_dist, v1, v2, d4, adr;
   logic signed [ABS_W-1:0]  absv;
   logic [19:0]              hi;

   // checks and field selection
   always_comb begin
      rel_dist = in_item.rel_dist;
      adr      = in_item.adr_dist;
      absv     = in_item.abs_val;
      v1       = rel_dist >>> 1;
      v2       = rel_dist >>> 2;
      d4       = rel_dist + DIST_W'(4);
      hi       = d4[31:12] + {19'b0, d4[11]};

      calc.is_data = 1'b0;
      calc.status  = ST_OK;
      calc.bytes   = 4'd4;
      calc.imm     = '0;
      calc.value   = '0;
      calc.word    = in_item.word;

      unique case (in_item.kind) inside
         KIND_RV_B: begin
            if (rel_dist[0])
               calc.status = ST_ALIGN;
            else if (!fits_signed(v1, 12))
               calc.status = ST_FIT;
            else
               calc.imm = {v1[11], v1[9:4], 13'b0, v1[3:0], v1[10], 7'b0};
         end
         KIND_RV_J: begin
            if (rel_dist[0])
               calc.status = ST_ALIGN;
            else if (!fits_signed(v1, 20))
               calc.status = ST_FIT;
            else
               calc.imm = {v1[19], v1[9:0], v1[10], v1[18:11], 12'b0};
         end
         KIND_HI20: begin
            if (!fits_signed(d4, 32))
               calc.status = ST_FIT;
            else
               calc.imm = {hi, 12'b0};
         end
         KIND_LO12: begin
            if (!fits_signed(d4, 32))
               calc.status = ST_FIT;
            else
               calc.imm = {d4[11:0], 20'b0};
         end
         KIND_ADR: begin
            // addend plays no part here
            if (!fits_signed(adr, 21))
               calc.status = ST_FIT;
            else
               calc.imm = {1'b0, adr[1:0], 5'b0, adr[20:2], 5'b0};
         end
         KIND_TBZ14: begin
            if (rel_dist[1:0] != 2'b00)
               calc.status = ST_ALIGN;
            else if (!fits_signed(v2, 14))
               calc.status = ST_FIT;
            else
               calc.imm = {13'b0, v2[13:0], 5'b0};
         end
         KIND_CB19: begin
            if (rel_dist[1:0] != 2'b00)
               calc.status = ST_ALIGN;
            else if (!fits_signed(v2, 19))
               calc.status = ST_FIT;
            else
               calc.imm = {8'b0, v2[18:0], 5'b0};
         end
         KIND_J26: begin
            if (rel_dist[1:0] != 2'b00)
               calc.status = ST_ALIGN;
            else if (!fits_signed(v2, 26))
               calc.status = ST_FIT;
            else
               calc.imm = {6'b0, v2[25:0]};
         end
         KIND_ABS64: begin
            // any pattern fits, negative values as two's complement
            calc.is_data = 1'b1;
            calc.bytes   = 4'd8;
            calc.value   = {{(64-ABS_W){absv[ABS_W-1]}}, absv};
         end
         KIND_ABS32, KIND_ABS32S: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd4;
            if (absv[ABS_W-1:32] != '0)
               calc.status = ST_FIT;
            else
               calc.value = {32'b0, absv[31:0]};
         end
         KIND_ABS16: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd2;
            if (absv[ABS_W-1:16] != '0)
               calc.status = ST_FIT;
            else
               calc.value = {48'b0, absv[15:0]};
         end
         KIND_ABS8: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd1;
            if (absv[ABS_W-1:8] != '0)
               calc.status = ST_FIT;
            else
               calc.value = {56'b0, absv[7:0]};
         end
         KIND_REL64: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd8;
            calc.value   = {{(64-DIST_W){rel_dist[DIST_W-1]}}, rel_dist};
         end
         KIND_REL32: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd4;
            if (!fits_signed(rel_dist, 32))
               calc.status = ST_FIT;
            else
               calc.value = {32'b0, rel_dist[31:0]};
         end
         KIND_REL16: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd2;
            if (!fits_signed(rel_dist, 16))
               calc.status = ST_FIT;
            else
               calc.value = {48'b0, rel_dist[15:0]};
         end
         KIND_REL8: begin
            calc.is_data = 1'b1;
            calc.bytes   = 4'd1;
            if (!fits_signed(rel_dist, 8))
               calc.status = ST_FIT;
            else
               calc.value = {56'b0, rel_dist[7:0]};
         end
         default: begin
            // unknown kinds leave the word untouched
            calc.status = ST_OK;
         end
      endcase
   end

   // stage handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign item_in   = (in_valid && in_ready) ? calc : item_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- design/rfp_merge.sv -----
// ---------------------------------------------------------------------------
// rfp_merge
// last stage: merges the field into the word or picks the data value,
// and holds the result beat as the output register
// ---------------------------------------------------------------------------
module rfp_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rfp_pkg::check_type    in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rfp_pkg::rsp_item_type out_item
);
   import rfp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in, calc;

   // field merge, error results give zero data or the unchanged word
   always_comb begin
      calc.write_bytes = in_item.bytes;
      calc.status      = in_item.status;
      if (in_item.is_data)
         calc.patched_value = (in_item.status == ST_OK) ? in_item.value : 64'd0;
      else
         calc.patched_value = {32'b0, in_item.word | in_item.imm};
   end

   // stage handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign item_in   = (in_valid && in_ready) ? calc : item_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- design/rfp_checker.sv -----
// ---------------------------------------------------------------------------
// rfp_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`include "relocation_field_patcher_top_assert.svh"

module rfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import rfp_pkg::*;

   // no result straight after reset
   `RFP_ASSERT_IMP(a_reset_empty, clock, 1'b0, $past(reset), !rsp_tvalid)

   // byte count is one of the data widths
   `RFP_ASSERT_IMP(a_bytes_legal, clock, reset, rsp_tvalid,
      rsp_tdata[67:64] == 4'd1 || rsp_tdata[67:64] == 4'd2 ||
      rsp_tdata[67:64] == 4'd4 || rsp_tdata[67:64] == 4'd8)

   // misalignment only arises on instruction kinds
   `RFP_ASSERT_IMP(a_align_word, clock, reset,
      rsp_tvalid && rsp_tuser == ST_ALIGN, rsp_tdata[67:64] == 4'd4)

   // narrow or wide data kinds in error return zero
   `RFP_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_tvalid && rsp_tuser != ST_OK && rsp_tdata[67:64] != 4'd4,
      rsp_tdata[63:0] == 64'd0)

   // stalled result beat holds
   `RFP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind relocation_field_patcher_top rfp_checker u_rfp_checker (.*);
